// ===== rtl/core/lewnd_pkg.sv =====
`default_nettype none
package lewnd_pkg;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // direction codes
  localparam logic [2:0] DIR_NONE = 3'd0;
  localparam logic [2:0] DIR_PX   = 3'd1;
  localparam logic [2:0] DIR_NX   = 3'd2;
  localparam logic [2:0] DIR_PY   = 3'd3;
  localparam logic [2:0] DIR_NY   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECIDE,
    ST_SCAN,
    ST_FINISH
  } lewnd_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic len_rd;
    logic edge_wr;
    logic len_inc;
    logic len_clr;
    logic scan_start;
    logic scan_step;
    logic finish;
  } lewnd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       in_range;
    logic       full;
    logic       empty;
    logic       more;
    logic       out_free;
  } lewnd_stat_t;

  function automatic logic [2:0] dir_reverse(input logic [2:0] d);
    logic [2:0] r;
    unique case (d)
      DIR_PX:  r = DIR_NX;
      DIR_NX:  r = DIR_PX;
      DIR_PY:  r = DIR_NY;
      DIR_NY:  r = DIR_PY;
      default: r = DIR_NONE;
    endcase
    return r;
  endfunction

  // pick the first direction unless a previous direction is given and the first is none or turns straight back
  function automatic logic [2:0] dir_choose(input logic [2:0] a, input logic [2:0] b,
                                            input logic [2:0] prev);
    logic [2:0] r;
    if (prev == DIR_NONE) begin
      r = a;
    end else if (a != DIR_NONE && prev != dir_reverse(a)) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lewnd_req_if.sv =====
`default_nettype none
interface lewnd_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [3:0]         list_id;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] last_x;
  logic signed [15:0] last_y;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic [2:0]         prev_dir;

  modport source (output valid, req_type, list_id, first_x, first_y, last_x, last_y,
                  cur_x, cur_y, prev_dir, input ready);
  modport sink (input valid, req_type, list_id, first_x, first_y, last_x, last_y,
                cur_x, cur_y, prev_dir, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lewnd_rsp_if.sv =====
`default_nettype none
interface lewnd_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] next_dir;
  logic       status;

  modport source (output valid, next_dir, status, input ready);
  modport sink (input valid, next_dir, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lattice_edge_walk_next_direction.sv =====
// Channel | Dir | Beat
// --------+-----+-----------------------------------------------------------
// req     | in  | req_type, list_id, first/last point, cur point, prev_dir
// rsp     | out | next_dir, status (one beat for every req beat)
//
// Append and clear pass through fetch, decide and finish before rsp valid; a query
// also scans its list between decide and finish, the edge memory giving one edge a cycle.
// One item is in work at a time; the next req beat is taken once the
// controller is back in idle and the rsp register is empty or its beat leaves.
// rst is synchronous: all lists read as empty straight after reset, no sweep.
// A stalled rsp holds its beat; req is not taken while that beat would be lost.
`default_nettype none
module lattice_edge_walk_next_direction
  import lewnd_pkg::*;
#(
  parameter int NUM_LISTS  = 16,
  parameter int LIST_DEPTH = 256,
  parameter int COORD_BITS = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  lewnd_req_if.sink  req,
  lewnd_rsp_if.source rsp
);

  lewnd_cmd_t  cmd;
  lewnd_stat_t st;

  lewnd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  lewnd_dp #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req_type  (req.req_type),
    .list_id   (req.list_id),
    .first_x   (req.first_x),
    .first_y   (req.first_y),
    .last_x    (req.last_x),
    .last_y    (req.last_y),
    .cur_x     (req.cur_x),
    .cur_y     (req.cur_y),
    .prev_dir  (req.prev_dir),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .next_dir  (rsp.next_dir),
    .status    (rsp.status)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lewnd_ctrl.sv =====
`default_nettype none
module lewnd_ctrl
  import lewnd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire lewnd_stat_t st,
  output lewnd_cmd_t       cmd
);

  lewnd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && st.out_free) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (st.req_type == REQ_QUERY && st.in_range && !st.empty) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (!st.more) state_next = ST_FINISH;
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = st.out_free;
        cmd.latch = req_valid && st.out_free;
      end
      ST_FETCH: cmd.len_rd = st.in_range;
      ST_DECIDE: begin
        unique case (st.req_type)
          REQ_APPEND: begin
            cmd.edge_wr = st.in_range && !st.full;
            cmd.len_inc = st.in_range && !st.full;
          end
          REQ_CLEAR: cmd.len_clr = st.in_range;
          REQ_QUERY: cmd.scan_start = st.in_range && !st.empty;
          default: ;
        endcase
      end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/lewnd_dp.sv =====
`default_nettype none
module lewnd_dp
  import lewnd_pkg::*;
#(
  parameter int NUM_LISTS  = 16,
  parameter int LIST_DEPTH = 256,
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lewnd_cmd_t  cmd,
  output lewnd_stat_t      st,
  input  wire logic [1:0]  req_type,
  input  wire logic [3:0]  list_id,
  input  wire logic [15:0] first_x,
  input  wire logic [15:0] first_y,
  input  wire logic [15:0] last_x,
  input  wire logic [15:0] last_y,
  input  wire logic [15:0] cur_x,
  input  wire logic [15:0] cur_y,
  input  wire logic [2:0]  prev_dir,
  input  wire logic        rsp_ready,
  output logic             rsp_valid,
  output logic [2:0]       next_dir,
  output logic             status
);

  localparam int LW        = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int IW        = $clog2(LIST_DEPTH);
  localparam int CW        = $clog2(LIST_DEPTH + 1);
  localparam int CB        = COORD_BITS;
  localparam int EW        = 4 * CB;
  localparam int MEM_DEPTH = NUM_LISTS * (2 ** IW);

  // low COORD_BITS bits of a field, zero padded when the field is narrower
  function automatic logic [CB-1:0] fit(input logic [15:0] f);
    logic [CB+15:0] w;
    w = {{CB{1'b0}}, f};
    return w[CB-1:0];
  endfunction

  // latched item
  logic [1:0]    req_q;
  logic [3:0]    list_q;
  logic [CB-1:0] fx_q, fy_q, lx_q, ly_q, px_q, py_q;
  logic [2:0]    prev_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q  <= req_type;
      list_q <= list_id;
      fx_q   <= fit(first_x);
      fy_q   <= fit(first_y);
      lx_q   <= fit(last_x);
      ly_q   <= fit(last_y);
      px_q   <= fit(cur_x);
      py_q   <= fit(cur_y);
      prev_q <= prev_dir;
    end
  end

  logic [LW+3:0] list_ext;
  logic [LW-1:0] lidx;
  logic          in_range;

  assign list_ext = {{LW{1'b0}}, list_q};
  assign lidx     = list_ext[LW-1:0];
  assign in_range = ({28'd0, list_q} < 32'(NUM_LISTS));

  // list lengths: memory plus per-list valid bits cleared by reset
  logic [CW-1:0]        len_mem [NUM_LISTS];
  logic [NUM_LISTS-1:0] len_vld;
  logic [CW-1:0]        len_rd_q;
  logic                 len_vld_q;
  logic [CW-1:0]        len;
  logic                 len_wr;
  logic [CW-1:0]        len_wdata;

  assign len       = len_vld_q ? len_rd_q : '0;
  assign len_wr    = cmd.len_inc || cmd.len_clr;
  assign len_wdata = cmd.len_clr ? '0 : len + CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.len_rd) begin
      len_rd_q  <= len_mem[lidx];
      len_vld_q <= len_vld[lidx];
    end
    if (len_wr) begin
      len_mem[lidx] <= len_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
    end else if (len_wr) begin
      len_vld[lidx] <= 1'b1;
    end
  end

  // edge store: one write or one read a cycle, read data registered
  logic [EW-1:0] edge_mem [MEM_DEPTH];
  logic [EW-1:0] edge_q;
  logic [CW-1:0] idx;
  logic          more;
  logic          edge_rd;
  logic [IW-1:0] rd_off;

  assign more    = idx < len;
  assign edge_rd = cmd.scan_start || (cmd.scan_step && more);
  assign rd_off  = cmd.scan_start ? '0 : idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.edge_wr) begin
      edge_mem[{lidx, len[IW-1:0]}] <= {fx_q, fy_q, lx_q, ly_q};
    end
    if (edge_rd) begin
      edge_q <= edge_mem[{lidx, rd_off}];
    end
  end

  // advance the scan index
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx <= CW'(1);
    end else if (cmd.scan_step && more) begin
      idx <= idx + CW'(1);
    end
  end

  // evaluate the edge read in the previous cycle
  logic [CB-1:0] e_fx, e_fy, e_lx, e_ly;
  logic [CB:0]   dx, dy;
  logic          touch_f, touch_l;
  logic [2:0]    dir;
  localparam logic [CB:0] ONE  = (CB + 1)'(1);
  localparam logic [CB:0] MONE = '1;

  assign {e_fx, e_fy, e_lx, e_ly} = edge_q;
  assign dx      = {e_fx[CB-1], e_fx} - {e_lx[CB-1], e_lx};
  assign dy      = {e_fy[CB-1], e_fy} - {e_ly[CB-1], e_ly};
  assign touch_f = (e_fx == px_q) && (e_fy == py_q);
  assign touch_l = (e_lx == px_q) && (e_ly == py_q);

  always_comb begin
    dir = DIR_NONE;
    if (touch_f) begin
      if (dx == MONE)      dir = DIR_PX;
      else if (dx == ONE)  dir = DIR_NX;
      else if (dy == MONE) dir = DIR_PY;
      else if (dy == ONE)  dir = DIR_NY;
    end else if (touch_l) begin
      if (dx == ONE)       dir = DIR_PX;
      else if (dx == MONE) dir = DIR_NX;
      else if (dy == ONE)  dir = DIR_PY;
      else if (dy == MONE) dir = DIR_NY;
    end
  end

  // keep the first two touching edges
  logic [1:0] found;
  logic [2:0] dir_a, dir_b;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      found <= 2'd0;
      dir_a <= DIR_NONE;
      dir_b <= DIR_NONE;
    end else if (cmd.scan_step && (touch_f || touch_l) && found != 2'd2) begin
      if (found == 2'd0) dir_a <= dir;
      else               dir_b <= dir;
      found <= found + 2'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      next_dir <= (req_q == REQ_QUERY && in_range) ? dir_choose(dir_a, dir_b, prev_q)
                                                   : DIR_NONE;
      status   <= (req_q == REQ_APPEND) && (!in_range || len == CW'(LIST_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign st.req_type = req_q;
  assign st.in_range = in_range;
  assign st.full     = (len == CW'(LIST_DEPTH));
  assign st.empty    = (len == '0);
  assign st.more     = more;
  assign st.out_free = !rsp_valid || rsp_ready;

endmodule
`default_nettype wire

// ===== rtl/core/lewnd_checker.sv =====
`default_nettype none
module lewnd_checker
  import lewnd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic [1:0] req_type,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [2:0] next_dir,
  input wire logic       status
);

  // hold the type of the item in work
  logic [1:0] last_type;

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) last_type <= req_type;
  end

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req beat taken while an item is in work");

  a_dir_query_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && last_type != REQ_QUERY |-> next_dir == DIR_NONE)
    else $error("direction given for an item that is not a query");

  a_status_append_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && last_type != REQ_APPEND |-> !status)
    else $error("drop flagged for an item that is not an append");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> next_dir <= DIR_NY)
    else $error("direction code out of range");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(next_dir) && $stable(status))
    else $error("stalled rsp beat changed");

endmodule

bind lattice_edge_walk_next_direction lewnd_checker u_lewnd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .next_dir  (rsp.next_dir),
  .status    (rsp.status)
);
`default_nettype wire

// ===== bench/tb_lattice_edge_walk_next_direction.sv =====
module tb_lattice_edge_walk_next_direction;
  import lewnd_pkg::*;

  localparam int LISTS = 16;
  localparam int DEPTH = 256;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1500;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam int IDLE_PERCENT = 24;

  typedef struct {
    logic [1:0]         req_type;
    logic [3:0]         list_id;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic [2:0]         prev_dir;
  } walk_req_t;

  typedef struct {
    logic [2:0] next_dir;
    logic       status;
  } walk_rsp_t;

  typedef struct {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
  } lat_edge_t;

  // Mirror of the edge lists plus the queue of responses still owed
  class walk_scoreboard;
    lat_edge_t   edges [LISTS][DEPTH];
    int unsigned fill [LISTS];
    walk_rsp_t   pending_q [$];
    int          errors;

    function new();
      foreach (fill[i]) fill[i] = 0;
      errors = 0;
    endfunction

    // direction of travel along an edge, leaving from the touched end
    function logic [2:0] step_dir(lat_edge_t e, bit at_first);
      int dx, dy, s;
      dx = int'(e.fx) - int'(e.lx);
      dy = int'(e.fy) - int'(e.ly);
      s  = at_first ? -1 : 1;
      if (dx == s) return DIR_PX;
      if (dx == -s) return DIR_NX;
      if (dy == s) return DIR_PY;
      if (dy == -s) return DIR_NY;
      return DIR_NONE;
    endfunction

    function logic [2:0] opposite(logic [2:0] d);
      case (d)
        DIR_PX:  return DIR_NX;
        DIR_NX:  return DIR_PX;
        DIR_PY:  return DIR_NY;
        DIR_NY:  return DIR_PY;
        default: return DIR_NONE;
      endcase
    endfunction

    // scan oldest first, keep the first two touching edges
    function logic [2:0] walk_answer(int unsigned lst, logic signed [15:0] px,
                                     logic signed [15:0] py, logic [2:0] prev);
      int hits;
      logic [2:0] a, b, d;
      hits = 0;
      a = DIR_NONE;
      b = DIR_NONE;
      for (int i = 0; i < fill[lst]; i++) begin
        if (edges[lst][i].fx == px && edges[lst][i].fy == py) begin
          d = step_dir(edges[lst][i], 1'b1);
        end else if (edges[lst][i].lx == px && edges[lst][i].ly == py) begin
          d = step_dir(edges[lst][i], 1'b0);
        end else begin
          continue;
        end
        hits++;
        if (hits == 1) a = d;
        else if (hits == 2) b = d;
      end
      if (prev == DIR_NONE) return a;
      if (a != DIR_NONE && prev != opposite(a)) return a;
      return b;
    endfunction

    function void note_request(walk_req_t r);
      walk_rsp_t e;
      e.next_dir = DIR_NONE;
      e.status   = 1'b0;
      case (r.req_type)
        REQ_APPEND: begin
          if (fill[r.list_id] >= DEPTH) begin
            e.status = 1'b1;
          end else begin
            edges[r.list_id][fill[r.list_id]] = '{r.first_x, r.first_y, r.last_x, r.last_y};
            fill[r.list_id]++;
          end
        end
        REQ_CLEAR: fill[r.list_id] = 0;
        REQ_QUERY: e.next_dir = walk_answer(r.list_id, r.cur_x, r.cur_y, r.prev_dir);
        default: ;
      endcase
      pending_q.push_back(e);
    endfunction

    function void check_result(logic [2:0] next_dir, logic status);
      walk_rsp_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual next_dir=%0d status=%0d",
                 $time, next_dir, status);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (next_dir !== e.next_dir) begin
        $display("%0t: next_dir mismatch: expected %0d, actual %0d",
                 $time, e.next_dir, next_dir);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lewnd_req_if req_ch ();
  lewnd_rsp_if rsp_ch ();

  lattice_edge_walk_next_direction #(
    .NUM_LISTS(LISTS),
    .LIST_DEPTH(DEPTH),
    .COORD_BITS(16)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  walk_scoreboard sb = new();
  bit          no_idle = 1'b0;
  bit          want_hold_off = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold_off && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Check every response beat
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.next_dir, rsp_ch.status);
  end

  function automatic walk_req_t noise_req();
    walk_req_t r;
    r.req_type = 2'($urandom_range(3));
    r.list_id  = 4'($urandom);
    r.first_x  = 16'($urandom);
    r.first_y  = 16'($urandom);
    r.last_x   = 16'($urandom);
    r.last_y   = 16'($urandom);
    r.cur_x    = 16'($urandom);
    r.cur_y    = 16'($urandom);
    r.prev_dir = 3'($urandom);
    return r;
  endfunction

  // Offer one beat, with a random gap first; valid is left high afterwards
  task automatic send_item(input walk_req_t r);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r.req_type;
    req_ch.list_id  <= r.list_id;
    req_ch.first_x  <= r.first_x;
    req_ch.first_y  <= r.first_y;
    req_ch.last_x   <= r.last_x;
    req_ch.last_y   <= r.last_y;
    req_ch.cur_x    <= r.cur_x;
    req_ch.cur_y    <= r.cur_y;
    req_ch.prev_dir <= r.prev_dir;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
    if (r.req_type != REQ_UNUSED) items_sent++;
  endtask

  task automatic append_edge(input logic [3:0] lst, input logic signed [15:0] fx,
                             input logic signed [15:0] fy, input logic signed [15:0] lx,
                             input logic signed [15:0] ly);
    walk_req_t r;
    r = noise_req();
    r.req_type = REQ_APPEND;
    r.list_id  = lst;
    r.first_x  = fx;
    r.first_y  = fy;
    r.last_x   = lx;
    r.last_y   = ly;
    send_item(r);
  endtask

  task automatic query_at(input logic [3:0] lst, input logic signed [15:0] px,
                          input logic signed [15:0] py, input logic [2:0] prev);
    walk_req_t r;
    r = noise_req();
    r.req_type = REQ_QUERY;
    r.list_id  = lst;
    r.cur_x    = px;
    r.cur_y    = py;
    r.prev_dir = prev;
    send_item(r);
  endtask

  task automatic clear_list(input logic [3:0] lst);
    walk_req_t r;
    r = noise_req();
    r.req_type = REQ_CLEAR;
    r.list_id  = lst;
    send_item(r);
  endtask

  // Hold the sender until every owed response has arrived
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Build a short lattice path in one list, then ask for directions along it and at random points
  task automatic walk_sequence();
    logic signed [15:0] xs [0:8];
    logic signed [15:0] ys [0:8];
    logic [3:0] lst;
    logic [2:0] prev;
    int steps, k;
    lst = 4'($urandom_range(LISTS - 1));
    if (sb.fill[lst] > 40 || $urandom_range(3) == 0) clear_list(lst);
    steps = $urandom_range(1, 8);
    case ($urandom_range(3))
      0: begin
        xs[0] = 16'($urandom);
        ys[0] = 16'($urandom);
      end
      1: begin
        xs[0] = 16'($urandom_range(1) ? 32767 - $urandom_range(3)
                                       : -32768 + $urandom_range(3));
        ys[0] = 16'($urandom_range(1) ? 32767 - $urandom_range(3)
                                       : -32768 + $urandom_range(3));
      end
      default: begin
        xs[0] = 16'($urandom_range(40) - 20);
        ys[0] = 16'($urandom_range(40) - 20);
      end
    endcase
    for (int i = 1; i <= steps; i++) begin
      xs[i] = xs[i-1];
      ys[i] = ys[i-1];
      case ($urandom_range(9))
        0: begin
          xs[i] = 16'($urandom);
          ys[i] = 16'($urandom);
        end
        1: begin
          xs[i] = xs[i-1] + 16'sd1;
          ys[i] = ys[i-1] + 16'sd1;
        end
        2, 3: xs[i] = xs[i-1] + 16'sd1;
        4, 5: xs[i] = xs[i-1] - 16'sd1;
        6, 7: ys[i] = ys[i-1] + 16'sd1;
        default: ys[i] = ys[i-1] - 16'sd1;
      endcase
      if ($urandom_range(1))
        append_edge(lst, xs[i-1], ys[i-1], xs[i], ys[i]);
      else
        append_edge(lst, xs[i], ys[i], xs[i-1], ys[i-1]);
      if ($urandom_range(11) == 0) send_item(noise_req());
    end
    repeat ($urandom_range(2, 6)) begin
      k = $urandom_range(steps);
      prev = 3'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4));
      if ($urandom_range(5) == 0)
        query_at(lst, 16'($urandom), 16'($urandom), prev);
      else
        query_at(lst, xs[k], ys[k], prev);
    end
  endtask

  // Wander a list past its capacity, query it while full, then empty it
  task automatic fill_to_capacity(input logic [3:0] lst);
    logic signed [15:0] x, y, nx, ny;
    clear_list(lst);
    x = 16'($urandom_range(7));
    y = 16'($urandom_range(7));
    repeat (DEPTH + 4) begin
      nx = x;
      ny = y;
      case ($urandom_range(3))
        0: nx = x + 16'sd1;
        1: nx = x - 16'sd1;
        2: ny = y + 16'sd1;
        default: ny = y - 16'sd1;
      endcase
      append_edge(lst, x, y, nx, ny);
      x = nx;
      y = ny;
    end
    repeat (3) query_at(lst, 16'($urandom_range(7)), 16'($urandom_range(7)),
                        3'($urandom_range(4)));
    query_at(lst, x, y, DIR_NONE);
    clear_list(lst);
  endtask

  initial begin
    walk_req_t r;
    bit filled, paused;
    filled = 1'b0;
    paused = 1'b0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_APPEND;
    req_ch.list_id  <= '0;
    req_ch.first_x  <= '0;
    req_ch.first_y  <= '0;
    req_ch.last_x   <= '0;
    req_ch.last_y   <= '0;
    req_ch.cur_x    <= '0;
    req_ch.cur_y    <= '0;
    req_ch.prev_dir <= DIR_NONE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty list answers none
    query_at(4'd0, 16'sd0, 16'sd0, DIR_NONE);
    // two unit edges from the origin; turning back falls to the second
    append_edge(4'd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0);
    append_edge(4'd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1);
    query_at(4'd0, 16'sd0, 16'sd0, DIR_NONE);
    query_at(4'd0, 16'sd0, 16'sd0, DIR_NX);
    query_at(4'd0, 16'sd0, 16'sd0, 3'd7);
    // coordinate extremes: a wrapping pair is not a unit edge
    append_edge(4'd15, 16'sd32767, 16'sh8000, 16'sh8000, 16'sh8000);
    append_edge(4'd15, 16'sd32767, 16'sh8000, 16'sd32766, 16'sh8000);
    query_at(4'd15, 16'sd32767, 16'sh8000, DIR_PY);
    query_at(4'd15, 16'sd32767, 16'sh8000, DIR_NONE);
    query_at(4'd15, 16'sh8000, 16'sh8000, 3'd5);
    // touch at the last point, a diagonal and a zero-length edge
    append_edge(4'd1, 16'sd5, 16'sd5, 16'sd5, 16'sd6);
    append_edge(4'd1, 16'sd5, 16'sd6, 16'sd6, 16'sd7);
    append_edge(4'd1, 16'sd5, 16'sd6, 16'sd5, 16'sd6);
    query_at(4'd1, 16'sd5, 16'sd6, DIR_NONE);
    query_at(4'd1, 16'sd5, 16'sd6, DIR_PY);
    query_at(4'd1, 16'sd5, 16'sd6, DIR_NX);
    query_at(4'd1, 16'sd6, 16'sd7, DIR_NONE);
    // unknown request changes nothing
    r = noise_req();
    r.req_type = REQ_UNUSED;
    send_item(r);
    clear_list(4'd0);
    query_at(4'd0, 16'sd0, 16'sd0, DIR_NONE);
    clear_list(4'd15);
    clear_list(4'd1);
    drain();

    // Random phase: mostly well-formed walks with noise between them
    while (items_sent < ITEM_TARGET) begin
      if (!filled && items_sent >= 300) begin
        fill_to_capacity(4'($urandom_range(LISTS - 1)));
        filled = 1'b1;
      end
      if (items_sent >= 600) want_hold_off = 1'b1;
      no_idle = (items_sent >= 900 && items_sent < 1100);
      if (!paused && items_sent >= 1200) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(7) == 0)
        repeat ($urandom_range(1, 5)) send_item(noise_req());
      else
        walk_sequence();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_q.size() != 0)
      $display("%0t: %0d responses never arrived", $time, sb.pending_q.size());
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
